// ----- hdl/rgba_alu_pkg.sv -----
package rgba_alu_pkg;

  localparam int CH_W    = 9;    // channel width, Q0.8 plus the 1.0 bit
  localparam int CH_ONE  = 256;  // 1.0 in channel units
  localparam int SC_W    = 16;   // scalar width, signed Q8.8
  localparam int OPX_W   = SC_W + 1;        // second multiplier operand, holds 256 - s
  localparam int PROD_W  = CH_W + 1 + OPX_W; // signed product width
  localparam int FRAC_W  = 8;
  localparam int QBITS   = 8;    // quotient bits produced by the divider
  localparam int REM_W   = SC_W - 1;  // positive divisor and remainder width
  localparam int NLANES  = 4;
  // lane: one setup stage then one stage per quotient bit
  localparam int LANE_LAT = QBITS + 1;
  // start to strobe, including the output register
  localparam int OUT_LAT  = LANE_LAT + 1;

  typedef enum logic [3:0] {
    F_ADD  = 4'd0,
    F_ADDS = 4'd1,
    F_SUB  = 4'd2,
    F_SUBS = 4'd3,
    F_MUL  = 4'd4,
    F_MULS = 4'd5,
    F_DIV  = 4'd6,
    F_DIVS = 4'd7,
    F_LERP = 4'd8,
    F_CMP  = 4'd9
  } func_t;

  typedef struct packed {
    func_t                  func;
    logic [CH_W-1:0]        first_red;
    logic [CH_W-1:0]        first_green;
    logic [CH_W-1:0]        first_blue;
    logic [CH_W-1:0]        first_alpha;
    logic [CH_W-1:0]        second_red;
    logic [CH_W-1:0]        second_green;
    logic [CH_W-1:0]        second_blue;
    logic [CH_W-1:0]        second_alpha;
    logic signed [SC_W-1:0] scalar_operand;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic            colors_equal;
  } out_word_t;

  typedef struct packed {
    func_t                  func;
    logic [CH_W-1:0]        a;
    logic [CH_W-1:0]        b;
    logic signed [SC_W-1:0] s;
  } lane_in_t;

  function automatic logic [CH_W-1:0] clamp_ch(input logic signed [PROD_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > PROD_W'(CH_ONE)) begin
      return CH_W'(CH_ONE);
    end else begin
      return v[CH_W-1:0];
    end
  endfunction

endpackage

// ----- hdl/rgba_alu_lane.sv -----
module rgba_alu_lane (
  input  logic                          clk,
  input  rgba_alu_pkg::lane_in_t        lane_in,
  output logic [rgba_alu_pkg::CH_W-1:0] lane_res
);
  import rgba_alu_pkg::*;

  // setup stage
  logic signed [CH_W:0]     a_s;
  logic signed [OPX_W-1:0]  a_x, b_x, s_x, mul_x, op_x;
  logic signed [PROD_W-1:0] sum_w;
  logic [CH_W-1:0]          add_nxt, div_fix_nxt;
  logic signed [PROD_W-1:0] prod0_nxt, prod1_nxt;
  logic                     dz, dneg, sat, div_iter_nxt;

  func_t                    func_r;
  logic signed [PROD_W-1:0] prod0_r, prod1_r;
  logic [CH_W-1:0]          add_r, div_fix_r;
  logic                     div_iter_r;
  logic [REM_W-1:0]         rem_r, dvs_r;

  // result of the non-iterating operations, from the setup registers
  logic [CH_W-1:0]          p_cl, q_cl, fixed_res;
  logic [CH_W:0]            lerp_sum;

  // one quotient bit per stage
  logic [REM_W-1:0] st_rem_r  [QBITS];
  logic [REM_W-1:0] st_dvs_r  [QBITS];
  logic [QBITS-1:0] st_q_r    [QBITS];
  logic             st_iter_r [QBITS];
  logic [CH_W-1:0]  st_res_r  [QBITS];

  logic [REM_W-1:0] it_rem  [QBITS];
  logic [REM_W-1:0] it_dvs  [QBITS];
  logic [QBITS-1:0] it_q    [QBITS];
  logic             it_iter [QBITS];
  logic [CH_W-1:0]  it_res  [QBITS];

  always_comb begin
    a_s   = $signed({1'b0, lane_in.a});
    a_x   = OPX_W'(a_s);
    b_x   = $signed({{(OPX_W-CH_W){1'b0}}, lane_in.b});
    s_x   = OPX_W'(lane_in.s);
    case (lane_in.func)
      F_MUL:   mul_x = b_x;
      F_LERP:  mul_x = OPX_W'(CH_ONE) - s_x;
      default: mul_x = s_x;
    endcase
    prod0_nxt = PROD_W'(a_x) * PROD_W'(mul_x);
    prod1_nxt = PROD_W'(b_x) * PROD_W'(s_x);

    op_x  = (lane_in.func inside {F_ADD, F_SUB, F_DIV}) ? b_x : s_x;
    if (lane_in.func inside {F_SUB, F_SUBS}) begin
      sum_w = PROD_W'(a_x) - PROD_W'(op_x);
    end else begin
      sum_w = PROD_W'(a_x) + PROD_W'(op_x);
    end
    add_nxt = clamp_ch(sum_w);

    // divisor is op_x too: b for plain divide, s for divide by scalar
    dz   = (op_x == '0);
    dneg = op_x[OPX_W-1];
    sat  = (a_x >= op_x);  // quotient would reach 1.0 or more
    if (dz) begin
      div_fix_nxt = (lane_in.a == '0) ? '0 : CH_W'(CH_ONE);
    end else if (dneg) begin
      div_fix_nxt = '0;
    end else begin
      div_fix_nxt = CH_W'(CH_ONE);
    end
    div_iter_nxt = (lane_in.func inside {F_DIV, F_DIVS}) && !dz && !dneg && !sat;
  end

  always_ff @(posedge clk) begin
    func_r     <= lane_in.func;
    prod0_r    <= prod0_nxt;
    prod1_r    <= prod1_nxt;
    add_r      <= add_nxt;
    div_fix_r  <= div_fix_nxt;
    div_iter_r <= div_iter_nxt;
    rem_r      <= REM_W'(lane_in.a);
    dvs_r      <= op_x[REM_W-1:0];
  end

  always_comb begin
    p_cl     = clamp_ch(prod0_r >>> FRAC_W);
    q_cl     = clamp_ch(prod1_r >>> FRAC_W);
    lerp_sum = {1'b0, p_cl} + {1'b0, q_cl};
    case (func_r)
      F_ADD, F_ADDS, F_SUB, F_SUBS: fixed_res = add_r;
      F_MUL, F_MULS:                fixed_res = p_cl;
      F_DIV, F_DIVS:                fixed_res = div_fix_r;
      F_LERP: begin
        fixed_res = (lerp_sum > (CH_W+1)'(CH_ONE)) ? CH_W'(CH_ONE) : lerp_sum[CH_W-1:0];
      end
      default:                      fixed_res = '0;
    endcase
  end

  // restoring division, remainder always below the divisor
  for (genvar k = 0; k < QBITS; k++) begin : g_div
    logic [REM_W-1:0] rem_in, dvs_in;
    logic [QBITS-1:0] q_in;
    logic             iter_in;
    logic [CH_W-1:0]  res_in;
    logic [REM_W:0]   two;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = rem_r;
      assign dvs_in  = dvs_r;
      assign q_in    = '0;
      assign iter_in = div_iter_r;
      assign res_in  = fixed_res;
    end else begin : g_next
      assign rem_in  = st_rem_r[k-1];
      assign dvs_in  = st_dvs_r[k-1];
      assign q_in    = st_q_r[k-1];
      assign iter_in = st_iter_r[k-1];
      assign res_in  = st_res_r[k-1];
    end

    always_comb begin
      two        = {rem_in, 1'b0};
      ge         = (two >= {1'b0, dvs_in});
      it_rem[k]  = ge ? REM_W'(two - {1'b0, dvs_in}) : two[REM_W-1:0];
      it_dvs[k]  = dvs_in;
      it_q[k]    = {q_in[QBITS-2:0], ge};
      it_iter[k] = iter_in;
      it_res[k]  = res_in;
    end

    always_ff @(posedge clk) begin
      st_rem_r[k]  <= it_rem[k];
      st_dvs_r[k]  <= it_dvs[k];
      st_q_r[k]    <= it_q[k];
      st_iter_r[k] <= it_iter[k];
      st_res_r[k]  <= it_res[k];
    end
  end

  assign lane_res = st_iter_r[QBITS-1] ? CH_W'(st_q_r[QBITS-1]) : st_res_r[QBITS-1];

endmodule

// ----- hdl/saturating_rgba_color_alu.sv -----
// Channel | Ports                          | Handshake
// input   | start, busy, in_data           | word taken when start && !busy
// result  | out_valid, out_data            | one-cycle strobe, no back-pressure
//
// One word per cycle; busy is never raised. Each taken word passes through one setup
// stage, then the eight quotient-bit stages of the per-lane divider that every
// operation goes through, then the output register.
// rst_n (synchronous) clears only the valid pipeline; words in flight are lost.
// The receiver cannot stall, so nothing ever waits inside the block.
module saturating_rgba_color_alu (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  rgba_alu_pkg::in_word_t  in_data,
  output logic                    out_valid,
  output rgba_alu_pkg::out_word_t out_data
);
  import rgba_alu_pkg::*;

  lane_in_t        lane_in  [NLANES];
  logic [CH_W-1:0] lane_res [NLANES];
  logic            eq_in;

  logic [LANE_LAT-1:0] vld_r, vld_nxt;
  logic [LANE_LAT-1:0] eq_r, eq_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r, out_data_nxt;

  assign busy = 1'b0;

  always_comb begin
    lane_in[0] = '{func: in_data.func, a: in_data.first_red,
                   b: in_data.second_red, s: in_data.scalar_operand};
    lane_in[1] = '{func: in_data.func, a: in_data.first_green,
                   b: in_data.second_green, s: in_data.scalar_operand};
    lane_in[2] = '{func: in_data.func, a: in_data.first_blue,
                   b: in_data.second_blue, s: in_data.scalar_operand};
    lane_in[3] = '{func: in_data.func, a: in_data.first_alpha,
                   b: in_data.second_alpha, s: in_data.scalar_operand};
    eq_in = (in_data.func == F_CMP) &&
            (in_data.first_red   == in_data.second_red) &&
            (in_data.first_green == in_data.second_green) &&
            (in_data.first_blue  == in_data.second_blue) &&
            (in_data.first_alpha == in_data.second_alpha);
  end

  for (genvar i = 0; i < NLANES; i++) begin : g_lane
    rgba_alu_lane u_lane (
      .clk      (clk),
      .lane_in  (lane_in[i]),
      .lane_res (lane_res[i])
    );
  end

  // merge: lanes plus the delayed compare flag into one result word
  always_comb begin
    vld_nxt       = {vld_r[LANE_LAT-2:0], start && !busy};
    eq_nxt        = {eq_r[LANE_LAT-2:0], eq_in};
    out_valid_nxt = vld_r[LANE_LAT-1];
    out_data_nxt  = '{out_red: lane_res[0], out_green: lane_res[1],
                      out_blue: lane_res[2], out_alpha: lane_res[3],
                      colors_equal: eq_r[LANE_LAT-1]};
    if (!rst_n) begin
      vld_nxt       = '0;
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    vld_r       <= vld_nxt;
    eq_r        <= eq_nxt;
    out_valid_r <= out_valid_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/rgba_alu_chk.sv -----
module rgba_alu_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input rgba_alu_pkg::in_word_t  in_data,
  input logic                    out_valid,
  input rgba_alu_pkg::out_word_t out_data
);
  import rgba_alu_pkg::*;

  // every taken word gives its result after a fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##OUT_LAT out_valid)
    else $error("result strobe missing after fixed latency");

  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_red <= CH_W'(CH_ONE) && out_data.out_green <= CH_W'(CH_ONE) &&
                  out_data.out_blue <= CH_W'(CH_ONE) && out_data.out_alpha <= CH_W'(CH_ONE))
    else $error("channel result above 1.0");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.func == F_CMP |-> ##OUT_LAT
      out_data.out_red == '0 && out_data.out_green == '0 &&
      out_data.out_blue == '0 && out_data.out_alpha == '0)
    else $error("compare word gave non-zero channels");

  a_eq_only_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.func != F_CMP |-> ##OUT_LAT !out_data.colors_equal)
    else $error("colors_equal set for a non-compare word");

endmodule

bind saturating_rgba_color_alu rgba_alu_chk u_rgba_alu_chk (.*);

// ----- tb/saturating_rgba_color_alu_tb.sv -----
module saturating_rgba_color_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgba_alu_pkg::*;

  // opcodes with no operation behind them
  localparam logic [3:0] UNUSED_LO = F_CMP + 4'd1;
  localparam logic [3:0] UNUSED_HI = 4'hF;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_data = '0;
  logic      out_valid;
  out_word_t out_data;

  out_word_t pending_pixels[$];
  int        mismatches = 0;

  saturating_rgba_color_alu u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("saturating_rgba_color_alu_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int sat_unit(int v);
    if (v < 0) begin
      return 0;
    end else if (v > CH_ONE) begin
      return CH_ONE;
    end
    return v;
  endfunction

  function automatic int lane_value(func_t f, int a, int b, int s);
    int p;
    int q;
    case (f)
      F_ADD:  return sat_unit(a + b);
      F_ADDS: return sat_unit(a + s);
      F_SUB:  return sat_unit(a - b);
      F_SUBS: return sat_unit(a - s);
      F_MUL:  return sat_unit((a * b) / CH_ONE);
      F_MULS: return sat_unit((a * s) / CH_ONE);
      F_DIV, F_DIVS: begin
        q = (f == F_DIV) ? b : s;
        if (q == 0) begin
          return (a == 0) ? 0 : CH_ONE;
        end else if (q < 0) begin
          return 0;
        end
        return sat_unit((a * CH_ONE) / q);
      end
      F_LERP: begin
        // each term saturated on its own before the sum
        p = sat_unit((a * (CH_ONE - s)) / CH_ONE);
        q = sat_unit((b * s) / CH_ONE);
        return sat_unit(p + q);
      end
      default: return 0;
    endcase
  endfunction

  function automatic out_word_t predict_pixel(in_word_t w);
    out_word_t r;
    int        s;
    s = $signed(w.scalar_operand);
    r.out_red   = CH_W'(lane_value(w.func, w.first_red,   w.second_red,   s));
    r.out_green = CH_W'(lane_value(w.func, w.first_green, w.second_green, s));
    r.out_blue  = CH_W'(lane_value(w.func, w.first_blue,  w.second_blue,  s));
    r.out_alpha = CH_W'(lane_value(w.func, w.first_alpha, w.second_alpha, s));
    r.colors_equal = (w.func == F_CMP) &&
                     (w.first_red   == w.second_red)   &&
                     (w.first_green == w.second_green) &&
                     (w.first_blue  == w.second_blue)  &&
                     (w.first_alpha == w.second_alpha);
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_red",      want.out_red,      out_data.out_red);
        check_field("out_green",    want.out_green,    out_data.out_green);
        check_field("out_blue",     want.out_blue,     out_data.out_blue);
        check_field("out_alpha",    want.out_alpha,    out_data.out_alpha);
        check_field("colors_equal", want.colors_equal, out_data.colors_equal);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // start stays high on return so back-to-back words need no extra edge
  task automatic send_pixel(in_word_t w);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(predict_pixel(w));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t make_word(func_t f, logic [CH_W-1:0] a,
                                         logic [CH_W-1:0] b,
                                         logic signed [SC_W-1:0] s);
    in_word_t w;
    w.func = f;
    w.first_red  = a; w.first_green  = a; w.first_blue  = a; w.first_alpha  = a;
    w.second_red = b; w.second_green = b; w.second_blue = b; w.second_alpha = b;
    w.scalar_operand = s;
    return w;
  endfunction

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CH_W'(CH_ONE);
      2:       return CH_W'($urandom_range(CH_ONE + 1, 511));
      default: return CH_W'($urandom_range(0, CH_ONE));
    endcase
  endfunction

  function automatic logic signed [SC_W-1:0] rand_scalar(func_t f);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SC_W'($urandom());
      2: return SC_W'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
      3: return -SC_W'($urandom_range(1, 600));
      default: begin
        if (f == F_LERP) return SC_W'($urandom_range(0, CH_ONE));
        return SC_W'($urandom_range(0, 600));
      end
    endcase
  endfunction

  function automatic in_word_t random_pixel();
    in_word_t w;
    if ($urandom_range(0, 99) < 6) begin
      w.func = func_t'($urandom_range(UNUSED_LO, UNUSED_HI));
    end else begin
      w.func = func_t'($urandom_range(F_ADD, F_CMP));
    end
    w.first_red    = rand_channel();
    w.first_green  = rand_channel();
    w.first_blue   = rand_channel();
    w.first_alpha  = rand_channel();
    w.second_red   = rand_channel();
    w.second_green = rand_channel();
    w.second_blue  = rand_channel();
    w.second_alpha = rand_channel();
    // compares mostly on matching colours, sometimes off by one lane
    if (w.func == F_CMP && $urandom_range(0, 2) != 0) begin
      w.second_red   = w.first_red;
      w.second_green = w.first_green;
      w.second_blue  = w.first_blue;
      w.second_alpha = w.first_alpha;
      if ($urandom_range(0, 3) == 0) w.second_blue = w.first_blue ^ CH_W'(1);
    end
    w.scalar_operand = rand_scalar(w.func);
    return w;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_saturation();
    send_pixel(make_word(F_ADD,  256, 256, 0));
    send_pixel(make_word(F_ADD,  511, 511, 0));
    send_pixel(make_word(F_ADDS, 100, 0, 16'sh7FFF));
    send_pixel(make_word(F_ADDS, 100, 0, 16'sh8000));
    send_pixel(make_word(F_SUB,  10, 200, 0));
    send_pixel(make_word(F_SUBS, 256, 0, -16'sd5));
    send_pixel(make_word(F_MUL,  256, 256, 0));
    send_pixel(make_word(F_MULS, 200, 0, -16'sd256));
    send_pixel(make_word(F_MULS, 511, 0, 16'sh7FFF));
  endtask

  task automatic test_division();
    send_pixel(make_word(F_DIV,  100, 0, 0));
    send_pixel(make_word(F_DIV,  0, 0, 0));
    send_pixel(make_word(F_DIV,  50, 200, 0));
    send_pixel(make_word(F_DIV,  511, 1, 0));
    send_pixel(make_word(F_DIVS, 100, 0, 0));
    send_pixel(make_word(F_DIVS, 100, 0, -16'sd3));
    send_pixel(make_word(F_DIVS, 7, 0, 16'sh7FFF));
  endtask

  task automatic test_lerp();
    send_pixel(make_word(F_LERP, 256, 0, 0));
    send_pixel(make_word(F_LERP, 256, 0, 16'sd256));
    send_pixel(make_word(F_LERP, 200, 60, 16'sd128));
    send_pixel(make_word(F_LERP, 511, 511, 16'sh8000));
    send_pixel(make_word(F_LERP, 511, 511, 16'sh7FFF));
  endtask

  task automatic test_compare_and_unused();
    in_word_t w;
    send_pixel(make_word(F_CMP, 511, 511, 0));
    w = make_word(F_CMP, 128, 128, 0);
    w.second_alpha = 9'd129;
    send_pixel(w);
    send_pixel(make_word(func_t'(UNUSED_LO), 256, 256, 16'sd256));
    send_pixel(make_word(func_t'(UNUSED_HI), 511, 511, 16'sh7FFF));
  endtask

  task automatic test_random_stream(int count, int gap_pct);
    repeat (count) begin
      // idle cycles make up about gap_pct of the cycles
      while ($urandom_range(0, 99) < gap_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
      send_pixel(random_pixel());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_saturation();
    test_division();
    test_lerp();
    test_compare_and_unused();
    wait_drained();

    test_random_stream(280, 23);
    wait_drained();
    test_random_stream(280, 52);
    wait_drained();
    test_random_stream(290, 0);
    wait_drained();

    repeat (OUT_LAT + 4) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("saturating_rgba_color_alu_tb: PASS");
    end else begin
      $display("saturating_rgba_color_alu_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rgba_alu_pkg.sv
hdl/rgba_alu_lane.sv
hdl/saturating_rgba_color_alu.sv
hdl/rgba_alu_chk.sv
tb/saturating_rgba_color_alu_tb.sv
